FILE: sv/vwc_pkg.sv
`default_nettype none
package vwc_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int MAX_DIM       = 1024;
	localparam int SAMPLE_W      = 16;
	localparam int INT_W         = FRACTION_BITS + 1;
	localparam int CLASS_W       = 8;
	localparam int COORD_W       = $clog2(MAX_DIM);
	localparam int DIM_W         = 11;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int NUM_W         = SAMPLE_W + FRACTION_BITS;
	localparam int QBITS         = INT_W;
	localparam int STEP_W        = $clog2(QBITS);
	localparam int Q_DEPTH       = 2;
	localparam int PTR_W         = $clog2(Q_DEPTH);
	localparam int CNT_W         = $clog2(Q_DEPTH + 1);

	localparam logic [INT_W-1:0] INT_ONE     = INT_W'(1) << FRACTION_BITS;
	localparam logic [DIM_W-1:0] DIM_MAX     = DIM_W'(MAX_DIM);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_LOW    = 3'd1,
		REG_HIGH   = 3'd2,
		REG_CLASSES = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5,
		REG_DEPTH  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic                  needs_div;
		logic [NUM_W-1:0]      num_int;
		logic [NUM_W-1:0]      num_cls;
		logic [SAMPLE_W-1:0]   divisor;
		logic [INT_W-1:0]      intensity;
		logic [CLASS_W-1:0]    class_index;
		logic                  discard;
		logic [COORD_W-1:0]    col;
		logic [COORD_W-1:0]    row;
		logic [COORD_W-1:0]    slice;
		logic                  last;
	} cmd_t;

endpackage
`default_nettype wire

FILE: sv/vwc_ifs.sv
`default_nettype none
interface vwc_in_if import vwc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface vwc_out_if import vwc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INT_W-1:0]   intensity;
	logic [CLASS_W-1:0] class_index;
	logic               discard;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] slice;
	logic               last;

	modport source (output valid, output intensity, output class_index, output discard,
		output col, output row, output slice, output last, input ready);
	modport sink (input valid, input intensity, input class_index, input discard,
		input col, input row, input slice, input last, output ready);
endinterface

interface vwc_cfg_if import vwc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/vwc_queue.sv
`default_nettype none
module vwc_queue import vwc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	cmd_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("request popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(Q_DEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: sv/vwc_front.sv
`default_nettype none
module vwc_front import vwc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vwc_in_if.sink     samples,
	vwc_cfg_if.sink    cfg,
	input  wire logic  q_full,
	output logic       q_push,
	output cmd_t       q_data
);

	logic                mode_q;
	logic [SAMPLE_W-1:0] low_q;
	logic [SAMPLE_W-1:0] high_q;
	logic [CLASS_W-1:0]  classes_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [DIM_W-1:0]    depth_q;
	logic [COORD_W-1:0]  col_q;
	logic [COORD_W-1:0]  row_q;
	logic [COORD_W-1:0]  slice_q;

	logic [DIM_W-1:0]    w_eff;
	logic [DIM_W-1:0]    h_eff;
	logic [DIM_W-1:0]    d_eff;
	logic                col_end;
	logic                row_end;
	logic                slice_end;
	logic [SAMPLE_W-1:0] delta;
	logic [SAMPLE_W-1:0] span;
	logic [SAMPLE_W+CLASS_W-1:0] prod;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		return (v == '0 || v > DIM_MAX) ? DIM_MAX : v;
	endfunction

	assign cfg.ready     = 1'b1;
	assign samples.ready = !q_full;
	assign q_push        = samples.valid && !q_full;

	assign w_eff     = eff_dim(width_q);
	assign h_eff     = eff_dim(height_q);
	assign d_eff     = eff_dim(depth_q);
	assign col_end   = ({1'b0, col_q} + DIM_W'(1)) >= w_eff;
	assign row_end   = ({1'b0, row_q} + DIM_W'(1)) >= h_eff;
	assign slice_end = ({1'b0, slice_q} + DIM_W'(1)) >= d_eff;

	assign delta = samples.sample - low_q;
	assign span  = high_q - low_q;
	assign prod  = (SAMPLE_W+CLASS_W)'(classes_q) * (SAMPLE_W+CLASS_W)'(delta);

	always_comb begin
		q_data             = '0;
		q_data.col         = col_q;
		q_data.row         = row_q;
		q_data.slice       = slice_q;
		q_data.last        = col_end && row_end && slice_end;
		priority if (!mode_q) begin
			// s * 2^16 / 255 rounded: s * 257 plus one for the upper half
			q_data.intensity = {1'b0, samples.sample[7:0], samples.sample[7:0]}
				+ INT_W'(samples.sample[7]);
		end else if (samples.sample < low_q) begin
			q_data.discard   = 1'b1;
		end else if (samples.sample >= high_q) begin
			q_data.intensity = INT_ONE;
			if (samples.sample == high_q) begin
				q_data.class_index = classes_q;
			end else begin
				q_data.discard = 1'b1;
			end
		end else begin
			q_data.needs_div = 1'b1;
			q_data.num_int   = {delta, FRACTION_BITS'(0)} + NUM_W'(span[SAMPLE_W-1:1]);
			q_data.num_cls   = NUM_W'(prod);
			q_data.divisor   = span;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			low_q     <= '0;
			high_q    <= '1;
			classes_q <= CLASS_W'(6);
			width_q   <= DIM_MAX;
			height_q  <= DIM_MAX;
			depth_q   <= DIM_MAX;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODE:    mode_q    <= cfg.data[0];
				REG_LOW:     low_q     <= cfg.data[SAMPLE_W-1:0];
				REG_HIGH:    high_q    <= cfg.data[SAMPLE_W-1:0];
				REG_CLASSES: classes_q <= cfg.data[CLASS_W-1:0];
				REG_WIDTH:   width_q   <= cfg.data[DIM_W-1:0];
				REG_HEIGHT:  height_q  <= cfg.data[DIM_W-1:0];
				REG_DEPTH:   depth_q   <= cfg.data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
		end else if (q_push) begin
			if (!col_end) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
				if (!row_end) begin
					row_q <= row_q + 1'b1;
				end else begin
					row_q <= '0;
					slice_q <= slice_end ? '0 : slice_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/vwc_back.sv
`default_nettype none
module vwc_back import vwc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire cmd_t q_head,
	output logic      q_pop,
	vwc_out_if.source results
);

	back_state_t         state_q;
	back_state_t         state_d;
	logic [STEP_W-1:0]   step_q;
	cmd_t                cmd_q;
	logic [SAMPLE_W-1:0] rem_int_q;
	logic [SAMPLE_W-1:0] rem_cls_q;
	logic [QBITS-1:0]    nq_int_q;
	logic [QBITS-1:0]    nq_cls_q;
	logic                out_valid_q;

	logic                out_free;
	logic                start;
	logic                load_direct;
	logic                load_div;
	logic [SAMPLE_W:0]   sh_int;
	logic [SAMPLE_W:0]   sh_cls;
	logic                ge_int;
	logic                ge_cls;
	logic [SAMPLE_W:0]   diff_int;
	logic [SAMPLE_W:0]   diff_cls;

	assign out_free      = !out_valid_q || results.ready;
	assign results.valid = out_valid_q;

	assign sh_int   = {rem_int_q, nq_int_q[QBITS-1]};
	assign sh_cls   = {rem_cls_q, nq_cls_q[QBITS-1]};
	assign ge_int   = sh_int >= {1'b0, cmd_q.divisor};
	assign ge_cls   = sh_cls >= {1'b0, cmd_q.divisor};
	assign diff_int = sh_int - {1'b0, cmd_q.divisor};
	assign diff_cls = sh_cls - {1'b0, cmd_q.divisor};

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		start       = 1'b0;
		load_direct = 1'b0;
		load_div    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_head.needs_div) begin
						q_pop   = 1'b1;
						start   = 1'b1;
						state_d = B_DIV;
					end else if (out_free) begin
						q_pop       = 1'b1;
						load_direct = 1'b1;
					end
				end
			end
			B_DIV: begin
				if (step_q == STEP_W'(QBITS - 1)) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					load_div = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_div) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q     <= q_head;
			step_q    <= '0;
			rem_int_q <= SAMPLE_W'(q_head.num_int[NUM_W-1:QBITS]);
			rem_cls_q <= SAMPLE_W'(q_head.num_cls[NUM_W-1:QBITS]);
			nq_int_q  <= q_head.num_int[QBITS-1:0];
			nq_cls_q  <= q_head.num_cls[QBITS-1:0];
		end else if (state_q == B_DIV) begin
			step_q    <= step_q + 1'b1;
			rem_int_q <= ge_int ? diff_int[SAMPLE_W-1:0] : sh_int[SAMPLE_W-1:0];
			rem_cls_q <= ge_cls ? diff_cls[SAMPLE_W-1:0] : sh_cls[SAMPLE_W-1:0];
			nq_int_q  <= {nq_int_q[QBITS-2:0], ge_int};
			nq_cls_q  <= {nq_cls_q[QBITS-2:0], ge_cls};
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			results.intensity   <= q_head.intensity;
			results.class_index <= q_head.class_index;
			results.discard     <= q_head.discard;
			results.col         <= q_head.col;
			results.row         <= q_head.row;
			results.slice       <= q_head.slice;
			results.last        <= q_head.last;
		end else if (load_div) begin
			results.intensity   <= nq_int_q;
			results.class_index <= nq_cls_q[CLASS_W-1:0];
			results.discard     <= 1'b0;
			results.col         <= cmd_q.col;
			results.row         <= cmd_q.row;
			results.slice       <= cmd_q.slice;
			results.last        <= cmd_q.last;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> step_q < STEP_W'(QBITS))
		else $error("divider step out of range");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == B_IDLE)
		else $error("request popped while divider busy");
	a_discard_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && results.discard |-> results.class_index == '0)
		else $error("discarded voxel carries a class");
	a_div_no_discard: assert property (@(posedge clk) disable iff (!arst_n)
		load_div |=> !results.discard)
		else $error("divided voxel flagged discard");

endmodule
`default_nettype wire

FILE: sv/voxel_window_classifier.sv
// A voxel that needs no division (8-bit mode, or outside the window or at its upper
// bound) goes via the request queue to the output register, one per cycle while
// results.ready holds and no division is under way. Inside the window, voxels go one
// at a time through the shared radix-2 divider, one quotient bit a cycle.
// A two-entry request queue sits between the front and the divider.
// Reset: arst_n clears counters, queue and control, and loads register defaults.
`default_nettype none
module voxel_window_classifier import vwc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	vwc_in_if.sink    samples,
	vwc_cfg_if.sink   cfg,
	vwc_out_if.source results
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_data;
	cmd_t q_head;

	vwc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	vwc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	vwc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule
`default_nettype wire
